// ===== hdl/venc_pkg.sv =====
// ----------------------------------------------------------------------------
// venc_pkg
// Shared codes, constants and controller/datapath interface types for the
// varint encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package venc_pkg;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned GROUP_W   = 7;
   localparam int unsigned HALF_W    = 32;
   localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7f;

   typedef enum logic [OP_W-1:0] {
      OP_UNSIGNED = 2'd0,
      OP_ZIGZAG   = 2'd1,
      OP_SIGNMAG  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   emit_sign;
      logic   emit_group;
   } cmd_type;

   typedef struct packed {
      logic more;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/venc_dp.sv =====
// ----------------------------------------------------------------------------
// venc_dp
// Datapath: value preparation (zigzag, sign/magnitude), 7-bit group shifter
// and the output byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module venc_dp
   import venc_pkg::*;
(
   input  wire logic               clock,
   input  wire cmd_type            cmd,
   input  wire logic [VALUE_W-1:0] value,
   output status_type              status,
   output logic [BYTE_W-1:0]       out_byte,
   output logic                    last
);

   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic               sign_ff, sign_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [HALF_W-1:0]  low;
   logic [HALF_W-1:0]  zig;
   logic               more;

   assign low  = value[HALF_W-1:0];
   assign zig  = {low[HALF_W-2:0], 1'b0} ^ {HALF_W{low[HALF_W-1]}};
   assign more = |rem_ff[VALUE_W-1:GROUP_W];

   always_comb begin
      rem_in  = rem_ff;
      sign_in = sign_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (cmd.load) begin
         unique case (cmd.op)
            OP_UNSIGNED: begin
               rem_in  = value;
               sign_in = 1'b0;
            end
            OP_ZIGZAG: begin
               rem_in  = {{(VALUE_W-HALF_W){1'b0}}, zig};
               sign_in = 1'b0;
            end
            OP_SIGNMAG: begin
               sign_in = value[VALUE_W-1];
               rem_in  = value[VALUE_W-1] ? (~value + 64'd1) : value;
            end
            default: begin
               rem_in  = rem_ff;
               sign_in = sign_ff;
            end
         endcase
      end else if (cmd.emit_sign) begin
         byte_in = {{(BYTE_W-1){1'b0}}, sign_ff};
         last_in = 1'b0;
      end else if (cmd.emit_group) begin
         byte_in = {more, rem_ff[GROUP_W-1:0] & GROUP_MASK};
         last_in = ~more;
         rem_in  = {{GROUP_W{1'b0}}, rem_ff[VALUE_W-1:GROUP_W]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sign_ff <= sign_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign status.more = more;
   assign out_byte    = byte_ff;
   assign last        = last_ff;

endmodule

`default_nettype wire

// ===== hdl/venc_ctrl.sv =====
// ----------------------------------------------------------------------------
// venc_ctrl
// Controller: input handshake, byte sequencing and output valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module venc_ctrl
   import venc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire status_type      status,
   output cmd_type              cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_GROUP
   } state_type;

   state_type state_ff;
   logic      valid_ff;
   logic      out_free;
   logic      accept;
   op_type    op;

   assign op       = op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && !req_stall;
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      cmd            = '0;
      cmd.op         = op;
      cmd.load       = accept && (op != OP_NONE);
      cmd.emit_sign  = (state_ff == ST_SIGN) && out_free;
      cmd.emit_group = (state_ff == ST_GROUP) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_sign || cmd.emit_group) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= (op == OP_SIGNMAG) ? ST_SIGN : ST_GROUP;
               end
            end
            ST_SIGN: begin
               if (cmd.emit_sign) begin
                  state_ff <= ST_GROUP;
               end
            end
            ST_GROUP: begin
               if (cmd.emit_group && !status.more) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !(cmd.emit_sign || cmd.emit_group))
      else $error("output byte overwritten while held");

   a_final_group: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_group && !status.more) |=> (state_ff == ST_IDLE) && valid_ff)
      else $error("final group did not return to idle");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && op == OP_SIGNMAG) |=> (state_ff == ST_SIGN))
      else $error("sign byte not scheduled");

   a_emit_loads_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_group) |=> valid_ff)
      else $error("emitted byte not presented");

endmodule

`default_nettype wire

// ===== hdl/varint_encoder_top.sv =====
// ----------------------------------------------------------------------------
// varint_encoder_top
// LEB128 varint encoder with zigzag and sign-byte modes.
// ----------------------------------------------------------------------------
// One item is encoded at a time. An accepted item is loaded, then the
// shifter emits one byte per cycle into the output register while the
// output is not stalled, least significant 7-bit group first: 1 to 10
// bytes, plus a leading sign byte for operation 2. The next item is taken
// in the cycle after the final byte is loaded. Operation 3 is accepted and
// produces no bytes. rsp_last marks the final byte of each encoding.
`default_nettype none

module varint_encoder_top
   import venc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_last
);

   cmd_type    cmd;
   status_type status;

   venc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   venc_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .value    (req_value),
      .status   (status),
      .out_byte (rsp_out_byte),
      .last     (rsp_last)
   );

endmodule

`default_nettype wire
